// ===== rtl/text_console_writer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property wrappers for the checker of the text console writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer check failed");

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Command codes, cell constants and the command record passed front to back.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int ADDR_W_MAX = 13;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] ERROR_CHAR   = 8'h45;
  localparam logic [7:0] DEFAULT_ATTR = 8'h0f;
  localparam logic [7:0] ERROR_ATTR   = 8'hf4;

  localparam logic TEXT_ATTR_IDX = 1'b0;

  typedef enum logic [1:0] {
    OP_PUT        = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_SET,
    CMD_SET_ERR,
    CMD_CLEAR,
    CMD_READ,
    CMD_READ_OFF
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_ZERO
  } back_state_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [7:0]            chr;
    logic [6:0]            col;
    logic [4:0]            row;
    logic [ADDR_W_MAX-1:0] line;
    logic [ADDR_W_MAX-1:0] addr;
  } cmd_t;

endpackage

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts input beats, checks positions and turns each beat into a command.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   op_i,
  input  logic [7:0]   char_code_i,
  input  logic [6:0]   col_i,
  input  logic [4:0]   row_i,
  input  logic         queue_full_i,
  input  logic         init_busy_i,
  output logic         push_o,
  output tcw_pkg::cmd_t cmd_o
);
  import tcw_pkg::*;

  localparam logic [7:0] ColsW = 8'(COLS);
  localparam logic [6:0] RowsW = 7'(ROWS);

  logic                  in_range;
  logic [ADDR_W_MAX-1:0] line;

  assign in_ready_o = !queue_full_i && !init_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign in_range = ({1'b0, col_i} < ColsW) && ({2'b00, row_i} < RowsW);
  assign line     = ADDR_W_MAX'(row_i) * ADDR_W_MAX'(COLS);

  always_comb begin
    cmd_o.chr  = char_code_i;
    cmd_o.col  = col_i;
    cmd_o.row  = row_i;
    cmd_o.line = line;
    cmd_o.addr = line + ADDR_W_MAX'(col_i);
    case (op_i)
      OP_PUT: begin
        cmd_o.kind = (char_code_i == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_PUT;
      end
      OP_SET_CURSOR: begin
        cmd_o.kind = in_range ? CMD_SET : CMD_SET_ERR;
      end
      OP_CLEAR: begin
        cmd_o.kind = CMD_CLEAR;
      end
      OP_READ: begin
        cmd_o.kind = in_range ? CMD_READ : CMD_READ_OFF;
      end
      default: begin
        cmd_o.kind = CMD_READ_OFF;
      end
    endcase
  end

endmodule

// ===== rtl/tcw_fifo.sv =====
// ----------------------------------------------------------------------------
// Text console writer command queue
// Two-entry queue that decouples the front end from the screen engine.
// ----------------------------------------------------------------------------
module tcw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tcw_pkg::cmd_t pop_cmd_o
);
  import tcw_pkg::*;

  cmd_t       entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_cmd_o = entries_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// Text console writer screen engine
// Owns the screen store and cursor, runs commands, sweeps and the result beat.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          init_busy_o,
  input  logic [7:0]    text_attr_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [6:0]    cursor_col_o,
  output logic [4:0]    cursor_row_o,
  output logic [7:0]    read_char_o,
  output logic [7:0]    read_attr_o,
  output logic          scrolled_o,
  output logic          error_o
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CLW   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RWW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [AW-1:0]  LastCell  = AW'(CELLS - 1);
  localparam logic [AW-1:0]  ScrollLen = AW'(CELLS - COLS);
  localparam logic [AW-1:0]  LastLine  = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0]  ColsA     = AW'(COLS);
  localparam logic [AW-1:0]  ZeroLast  = AW'(COLS - 1);
  localparam logic [CLW-1:0] LastCol   = CLW'(COLS - 1);
  localparam logic [RWW-1:0] LastRow   = RWW'(ROWS - 1);

  back_state_e state_q, state_d;

  logic [15:0]    mem_q [CELLS];
  logic [15:0]    rdata_q;
  logic [AW-1:0]  k_q, k_d;
  logic [CLW-1:0] col_q, col_d;
  logic [RWW-1:0] row_q, row_d;
  logic [AW-1:0]  line_q, line_d;
  logic           pend_q, pend_d;
  logic           init_q, init_d;
  logic           out_valid_q, out_valid_d;
  logic [6:0]     ocol_q, ocol_d;
  logic [4:0]     orow_q, orow_d;
  logic [7:0]     ochar_q, ochar_d;
  logic [7:0]     oattr_q, oattr_d;
  logic           oscr_q, oscr_d;
  logic           oerr_q, oerr_d;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [15:0]    wdata;
  logic           re;
  logic [AW-1:0]  raddr;
  logic           load;
  logic [7:0]     ld_char;
  logic [7:0]     ld_attr;
  logic           ld_scr;
  logic           ld_err;
  logic           out_free;
  logic           take;
  logic           wrap;
  logic           scroll;
  logic [AW-1:0]  cur_addr;
  logic [7:0]     attr_eff;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign wrap     = (cmd_i.kind == CMD_NEWLINE) || (col_q == LastCol);
  assign scroll   = wrap && (row_q == LastRow);
  assign cur_addr = line_q + AW'(col_q);
  assign attr_eff = (text_attr_i != 8'h00) ? text_attr_i : DEFAULT_ATTR;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (k_q == LastCell) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          case (cmd_i.kind)
            CMD_PUT, CMD_NEWLINE: begin
              if (scroll) begin
                state_d = ST_SCROLL;
              end
            end
            CMD_CLEAR: begin
              state_d = ST_FILL;
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        if (k_q == ScrollLen) begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (k_q == ZeroLast) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    k_d       = k_q;
    col_d     = col_q;
    row_d     = row_q;
    line_d    = line_q;
    pend_d    = pend_q;
    init_d    = init_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    waddr     = k_q;
    wdata     = 16'h0000;
    re        = 1'b0;
    raddr     = k_q;
    load      = 1'b0;
    ld_char   = 8'h00;
    ld_attr   = 8'h00;
    ld_scr    = 1'b0;
    ld_err    = 1'b0;
    case (state_q)
      ST_FILL: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = {DEFAULT_ATTR, BLANK_CHAR};
        k_d   = k_q + AW'(1);
        if (k_q == LastCell) begin
          k_d    = '0;
          init_d = 1'b0;
          pend_d = 1'b0;
          load   = pend_q;
        end
      end
      ST_IDLE: begin
        if (take) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_PUT, CMD_NEWLINE: begin
              if (cmd_i.kind == CMD_PUT) begin
                we    = 1'b1;
                waddr = cur_addr;
                wdata = {attr_eff, cmd_i.chr};
              end
              if (wrap) begin
                col_d = '0;
                if (!scroll) begin
                  row_d  = row_q + RWW'(1);
                  line_d = line_q + ColsA;
                end
              end else begin
                col_d = col_q + CLW'(1);
              end
              k_d  = '0;
              load = !scroll;
            end
            CMD_SET: begin
              col_d  = CLW'(cmd_i.col);
              row_d  = RWW'(cmd_i.row);
              line_d = cmd_i.line[AW-1:0];
              load   = 1'b1;
            end
            CMD_SET_ERR: begin
              we     = 1'b1;
              waddr  = LastCell;
              wdata  = {ERROR_ATTR, ERROR_CHAR};
              ld_err = 1'b1;
              load   = 1'b1;
            end
            CMD_CLEAR: begin
              col_d  = '0;
              row_d  = '0;
              line_d = '0;
              k_d    = '0;
              pend_d = 1'b1;
            end
            CMD_READ: begin
              re    = 1'b1;
              raddr = cmd_i.addr[AW-1:0];
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load    = 1'b1;
        ld_char = rdata_q[7:0];
        ld_attr = rdata_q[15:8];
      end
      ST_SCROLL: begin
        if (k_q != ScrollLen) begin
          re    = 1'b1;
          raddr = k_q + ColsA;
          k_d   = k_q + AW'(1);
        end else begin
          k_d = '0;
        end
        if (k_q != '0) begin
          we    = 1'b1;
          waddr = k_q - AW'(1);
          wdata = rdata_q;
        end
      end
      ST_ZERO: begin
        we    = 1'b1;
        waddr = LastLine + k_q;
        wdata = 16'h0000;
        k_d   = k_q + AW'(1);
        if (k_q == ZeroLast) begin
          k_d    = '0;
          load   = 1'b1;
          ld_scr = 1'b1;
        end
      end
      default: begin
        k_d = '0;
      end
    endcase

    out_valid_d = load ? 1'b1 : (out_valid_q && !out_ready_i);
    ocol_d      = load ? 7'(col_d) : ocol_q;
    orow_d      = load ? 5'(row_d) : orow_q;
    ochar_d     = load ? ld_char : ochar_q;
    oattr_d     = load ? ld_attr : oattr_q;
    oscr_d      = load ? ld_scr : oscr_q;
    oerr_d      = load ? ld_err : oerr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      k_q         <= '0;
      col_q       <= '0;
      row_q       <= '0;
      line_q      <= '0;
      pend_q      <= 1'b0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      col_q       <= col_d;
      row_q       <= row_d;
      line_q      <= line_d;
      pend_q      <= pend_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ocol_q  <= ocol_d;
    orow_q  <= orow_d;
    ochar_q <= ochar_d;
    oattr_q <= oattr_d;
    oscr_q  <= oscr_d;
    oerr_q  <= oerr_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign init_busy_o  = init_q;
  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = ocol_q;
  assign cursor_row_o = orow_q;
  assign read_char_o  = ochar_q;
  assign read_attr_o  = oattr_q;
  assign scrolled_o   = oscr_q;
  assign error_o      = oerr_q;

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell text console with a screen store, a cursor and a result beat
// for every command.
// ----------------------------------------------------------------------------
// Commands arrive on the input channel (op, char_code, col, row) and every
// command returns exactly one result beat on the output channel with the
// cursor after the command, the cell read, and the scroll and error flags.
// A beat passes a two-entry queue and the registered result stage before it
// is presented. Puts and newlines that do not scroll, cursor moves and
// off-screen reads sustain one beat per cycle while the output is not
// stalled; a read of a cell also passes the read state, as the screen store
// has a registered read port, so the engine takes no new command meanwhile.
// A put or newline that runs off the last row scrolls the store one entry
// per cycle through that port and then zeroes the last row; a clear writes
// every cell once. After reset the store is blanked by one pass over every
// cell, during which no input beat is accepted; the attribute register can
// be written over the APB port at any time.
// A stalled output holds its result, the queue fills and input ready drops.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  col_i,
  input  logic [4:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [7:0]  read_char_o,
  output logic [7:0]  read_attr_o,
  output logic        scrolled_o,
  output logic        error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcw_pkg::*;

  cmd_t       front_cmd;
  cmd_t       queue_cmd;
  logic       push;
  logic       queue_full;
  logic       queue_valid;
  logic       pop;
  logic       init_busy;
  logic [7:0] text_attr_q, text_attr_d;

  assign pready = 1'b1;

  always_comb begin
    text_attr_d = text_attr_q;
    if (psel && penable && pwrite && pready && (paddr[2] == TEXT_ATTR_IDX)) begin
      text_attr_d = pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'h0000_0000;
    if (paddr[2] == TEXT_ATTR_IDX) begin
      prdata = {24'h00_0000, text_attr_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= DEFAULT_ATTR;
    end else begin
      text_attr_q <= text_attr_d;
    end
  end

  tcw_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .char_code_i (char_code_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .queue_full_i(queue_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tcw_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(front_cmd),
    .full_o    (queue_full),
    .pop_i     (pop),
    .valid_o   (queue_valid),
    .pop_cmd_o (queue_cmd)
  );

  tcw_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (pop),
    .init_busy_o (init_busy),
    .text_attr_i (text_attr_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .read_char_o (read_char_o),
    .read_attr_o (read_attr_o),
    .scrolled_o  (scrolled_o),
    .error_o     (error_o)
  );

endmodule

// ===== rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_defines.svh"

module tcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] cursor_col_o,
  input logic [4:0] cursor_row_o,
  input logic [7:0] read_char_o,
  input logic [7:0] read_attr_o,
  input logic       scrolled_o,
  input logic       error_o
);

  `TCW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(cursor_col_o) && $stable(cursor_row_o) && $stable(read_char_o))

  `TCW_ASSERT(a_col_on_screen, clk_i, rst_ni, out_valid_o, 8'(cursor_col_o) < 8'(COLS))

  `TCW_ASSERT(a_error_alone, clk_i, rst_ni, out_valid_o && error_o, !scrolled_o && read_char_o == 8'h00 && read_attr_o == 8'h00)

  `TCW_ASSERT(a_scroll_home, clk_i, rst_ni, out_valid_o && scrolled_o, cursor_row_o == 5'(ROWS - 1) && cursor_col_o == 7'd0)

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .cursor_col_o(cursor_col_o),
  .cursor_row_o(cursor_row_o),
  .read_char_o (read_char_o),
  .read_attr_o (read_attr_o),
  .scrolled_o  (scrolled_o),
  .error_o     (error_o)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives commands into the console, predicts each result beat from a model
// of the screen, the cursor and the attribute register, and compares every
// returned beat field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam logic [2:0] TEXT_ATTR_ADDR = 3'(4 * int'(TEXT_ATTR_IDX));
  localparam int PHASE_ITEMS = 106;

  typedef struct {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic       scrolled;
    logic       error;
  } console_beat_t;

  class console_scoreboard;
    logic [15:0]   cells[SCREEN_CELLS];
    int unsigned   cursor;
    logic [7:0]    text_attr;
    console_beat_t awaited[$];
    int unsigned   errors;
    int unsigned   checked;

    function new();
      blank_screen();
      text_attr = DEFAULT_ATTR;
      errors = 0;
      checked = 0;
    endfunction

    function void blank_screen();
      for (int i = 0; i < SCREEN_CELLS; i++) cells[i] = {DEFAULT_ATTR, BLANK_CHAR};
      cursor = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endfunction

    function void note_command(op_e op, logic [7:0] chr, logic [6:0] col, logic [4:0] row);
      console_beat_t want;
      int unsigned   pos;
      logic [15:0]   stored;
      want = '{default: '0};
      if (cursor >= SCREEN_CELLS) cursor = 0;
      case (op)
        OP_PUT: begin
          pos = cursor;
          if (chr == NEWLINE_CHAR) begin
            pos = (pos / SCREEN_COLS + 1) * SCREEN_COLS;
          end else begin
            cells[pos] = {(text_attr != 8'h00) ? text_attr : DEFAULT_ATTR, chr};
            pos++;
          end
          if (pos >= SCREEN_CELLS) begin
            for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) cells[i] = cells[i + SCREEN_COLS];
            for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) cells[i] = 16'h0000;
            pos -= SCREEN_COLS;
            want.scrolled = 1'b1;
          end
          cursor = pos;
        end
        OP_SET_CURSOR: begin
          if (col >= SCREEN_COLS || row >= SCREEN_ROWS) begin
            cells[SCREEN_CELLS - 1] = {ERROR_ATTR, ERROR_CHAR};
            want.error = 1'b1;
          end else begin
            cursor = row * SCREEN_COLS + col;
          end
        end
        OP_CLEAR: begin
          blank_screen();
        end
        default: begin
          if (col < SCREEN_COLS && row < SCREEN_ROWS) begin
            stored = cells[row * SCREEN_COLS + col];
            want.read_char = stored[7:0];
            want.read_attr = stored[15:8];
          end
        end
      endcase
      want.cursor_col = 7'(cursor % SCREEN_COLS);
      want.cursor_row = 5'(cursor / SCREEN_COLS);
      awaited.push_back(want);
    endfunction

    function void check_beat(console_beat_t got);
      console_beat_t want;
      if (awaited.size() == 0) begin
        report("result beat arrived with no command outstanding");
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.cursor_col !== want.cursor_col)
        report($sformatf("beat %0d cursor_col %0d, expected %0d", checked, got.cursor_col,
                         want.cursor_col));
      if (got.cursor_row !== want.cursor_row)
        report($sformatf("beat %0d cursor_row %0d, expected %0d", checked, got.cursor_row,
                         want.cursor_row));
      if (got.read_char !== want.read_char)
        report($sformatf("beat %0d read_char %h, expected %h", checked, got.read_char,
                         want.read_char));
      if (got.read_attr !== want.read_attr)
        report($sformatf("beat %0d read_attr %h, expected %h", checked, got.read_attr,
                         want.read_attr));
      if (got.scrolled !== want.scrolled)
        report($sformatf("beat %0d scrolled %b, expected %b", checked, got.scrolled,
                         want.scrolled));
      if (got.error !== want.error)
        report($sformatf("beat %0d error %b, expected %b", checked, got.error, want.error));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  char_code_i = '0;
  logic [6:0]  col_i = '0;
  logic [4:0]  row_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [7:0]  read_char_o;
  logic [7:0]  read_attr_o;
  logic        scrolled_o;
  logic        error_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  console_scoreboard sb;
  bit calm = 1'b0;

  text_console_writer_unit #(
    .COLS(SCREEN_COLS),
    .ROWS(SCREEN_ROWS)
  ) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .op_i, .char_code_i, .col_i, .row_i,
    .out_valid_o, .out_ready_i, .cursor_col_o, .cursor_row_o,
    .read_char_o, .read_attr_o, .scrolled_o, .error_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_command(op_e op, logic [7:0] chr, logic [6:0] col, logic [4:0] row);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    char_code_i <= chr;
    col_i       <= col;
    row_i       <= row;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(op, chr, col, row);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
  endtask

  task automatic write_text_attr(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TEXT_ATTR_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.text_attr = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== value)
      sb.report($sformatf("text_attr read back %h, expected %h", prdata[7:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_phase(int unsigned count);
    int unsigned issued;
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    logic [6:0]  c;
    logic [4:0]  r;
    issued = 0;
    while (issued < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        r = ($urandom_range(0, 99) < 30) ? 5'(SCREEN_ROWS - 1)
                                         : 5'($urandom_range(0, SCREEN_ROWS - 1));
        c = 7'($urandom_range(0, SCREEN_COLS - 1));
        send_command(OP_SET_CURSOR, 8'($urandom), c, r);
        n = $urandom_range(1, 8);
        repeat (n)
          send_command(OP_PUT, ($urandom_range(0, 99) < 15) ? NEWLINE_CHAR : 8'($urandom),
                       7'($urandom), 5'($urandom));
        k = $urandom_range(0, 2);
        repeat (k)
          send_command(OP_READ, 8'($urandom), 7'(c + $urandom_range(0, n - 1)), r);
        issued += 1 + n + k;
      end else if (kind < 65) begin
        send_command(op_e'($urandom_range(0, 3)), 8'($urandom), 7'($urandom), 5'($urandom));
        issued++;
      end else if (kind < 85) begin
        if ($urandom_range(0, 99) < 70)
          send_command(OP_READ, 8'($urandom), 7'($urandom_range(0, SCREEN_COLS - 1)),
                       5'($urandom_range(0, SCREEN_ROWS - 1)));
        else
          send_command(OP_READ, 8'($urandom), 7'($urandom), 5'($urandom));
        issued++;
      end else if (kind < 90) begin
        send_command(OP_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
        issued++;
      end else begin
        send_command(OP_SET_CURSOR, 8'($urandom), 7'($urandom_range(SCREEN_COLS, 127)),
                     5'($urandom));
        send_command(OP_READ, 8'($urandom), 7'(SCREEN_COLS - 1), 5'(SCREEN_ROWS - 1));
        issued += 2;
      end
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    console_beat_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{cursor_col_o, cursor_row_o, read_char_o, read_attr_o, scrolled_o, error_o};
      sb.check_beat(got);
    end
  end

  initial begin : result_sink
    int unsigned stall;
    bit          held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && sb.checked >= 150) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        stall = calm ? 0 : idle_len();
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] phase_attr[5];
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(OP_READ, 8'h00, 7'd0, 5'd0);
    send_command(OP_PUT, 8'h48, 7'd0, 5'd0);
    send_command(OP_PUT, 8'h00, 7'd127, 5'd31);
    send_command(OP_PUT, 8'hff, 7'd0, 5'd0);
    send_command(OP_PUT, NEWLINE_CHAR, 7'd0, 5'd0);
    send_command(OP_READ, 8'hff, 7'd0, 5'd0);
    send_command(OP_READ, 8'h00, 7'd2, 5'd0);
    send_command(OP_SET_CURSOR, 8'h00, 7'(SCREEN_COLS - 1), 5'(SCREEN_ROWS - 1));
    send_command(OP_PUT, 8'h5a, 7'd0, 5'd0);
    send_command(OP_READ, 8'h00, 7'(SCREEN_COLS - 1), 5'(SCREEN_ROWS - 2));
    send_command(OP_READ, 8'h00, 7'd0, 5'(SCREEN_ROWS - 1));
    send_command(OP_SET_CURSOR, 8'h00, 7'd3, 5'(SCREEN_ROWS - 1));
    send_command(OP_PUT, NEWLINE_CHAR, 7'd0, 5'd0);
    send_command(OP_SET_CURSOR, 8'h00, 7'(SCREEN_COLS), 5'd0);
    send_command(OP_SET_CURSOR, 8'h00, 7'd0, 5'(SCREEN_ROWS));
    send_command(OP_SET_CURSOR, 8'hff, 7'd127, 5'd31);
    send_command(OP_READ, 8'h00, 7'(SCREEN_COLS - 1), 5'(SCREEN_ROWS - 1));
    send_command(OP_READ, 8'h00, 7'd127, 5'd31);
    send_command(OP_READ, 8'h00, 7'(SCREEN_COLS), 5'd0);
    send_command(OP_SET_CURSOR, 8'h00, 7'd0, 5'd0);
    send_command(OP_CLEAR, 8'h00, 7'd0, 5'd0);
    send_command(OP_READ, 8'h00, 7'(SCREEN_COLS - 1), 5'(SCREEN_ROWS - 1));
    drain_results();

    // A zero attribute is stored as the default attribute.
    write_text_attr(8'h00);
    send_command(OP_PUT, 8'h61, 7'd0, 5'd0);
    send_command(OP_READ, 8'h00, 7'd0, 5'd0);

    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hff;
    phase_attr[2] = 8'($urandom);
    phase_attr[3] = 8'h80;
    phase_attr[4] = 8'h01;
    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_text_attr(phase_attr[p]);
      calm = (p == 3);
      run_random_phase(PHASE_ITEMS);
    end
    calm = 1'b0;
    drain_results();
    repeat (50) @(posedge clk_i);

    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== text_console_writer_unit.f =====
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_fifo.sv
rtl/tcw_back.sv
rtl/text_console_writer_unit.sv
rtl/tcw_checker.sv
dv/tb.sv
